// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fpgu_pkg.sv -----
// Package: widths, codes, reset values and interface structs of the game update unit.
package fpgu_pkg;

  localparam int MAX_POPULATION = 4096;
  localparam int ONE_Q16        = 65536;

  localparam int CW    = 13;            // counts and population size
  localparam int DW    = CW - 1;        // N-1
  localparam int RW    = 16;            // random fractions
  localparam int WW    = 17;            // selection strength, 1 - w, 1 - r
  localparam int PARW  = 16;            // b and c
  localparam int PAYW  = 30;            // payoff numerators and small products
  localparam int WPW   = 47;            // w * payoff
  localparam int PKW   = 29;            // uniform pick compares
  localparam int XW    = 60;            // multiplicand
  localparam int YW    = 17;            // multiplier
  localparam int DIGW  = 4;             // multiplier digit per cycle
  localparam int MUL_STEPS = (YW + DIGW - 1) / DIGW;
  localparam int STEPW = $clog2(MUL_STEPS);
  localparam int PW    = XW + YW + 1;   // product

  localparam int CIW = 3;               // config index width
  localparam int CDW = 17;              // config data width

  // config register indexes
  localparam logic [CIW-1:0] CFG_POPULATION_SIZE    = 3'd0;
  localparam logic [CIW-1:0] CFG_SELECTION_STRENGTH = 3'd1;
  localparam logic [CIW-1:0] CFG_BENEFIT            = 3'd2;
  localparam logic [CIW-1:0] CFG_COST_TERM          = 3'd3;
  localparam logic [CIW-1:0] CFG_UPDATE_RULE        = 3'd4;
  localparam logic [CIW-1:0] CFG_INITIAL_COUNT      = 3'd5;

  localparam logic [CW-1:0]   RST_POPULATION_SIZE    = 13'd100;
  localparam logic [WW-1:0]   RST_SELECTION_STRENGTH = 17'd6554;
  localparam logic [PARW-1:0] RST_BENEFIT            = 16'd256;
  localparam logic [PARW-1:0] RST_COST_TERM          = 16'd128;
  localparam logic            RST_UPDATE_RULE        = 1'b0;
  localparam logic [CW-1:0]   RST_INITIAL_COUNT      = 13'd50;

  localparam logic RULE_MORAN = 1'b0;
  localparam logic RULE_LOCAL = 1'b1;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_INC  = 2'd1,
    CHG_DEC  = 2'd2
  } change_t;

  // product steps run on the shared multiplier
  typedef enum logic [3:0] {
    OP_BN,   // b * (N-i)
    OP_CD,   // c * (N-1)
    OP_WD,   // (1-w) * (N-1)
    OP_WPA,  // w * pi_a
    OP_WPB,  // w * pi_b
    OP_FA,   // fitness sum A
    OP_FB,   // fitness sum B
    OP_LFT,  // FB * r1
    OP_RGT,  // FA * (1-r1)
    OP_QE,   // |b+c| * (N-1)
    OP_LHS,  // q * r3
    OP_WG    // w * signed payoff gap
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PICK,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [CW-1:0]          population_size;
    logic [WW-1:0]          selection_strength;
    logic signed [PARW-1:0] benefit;
    logic signed [PARW-1:0] cost_term;
    logic                   update_rule;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic pick;
    logic mul_start;
    op_t  op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic rule;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/fpgu_mul.sv -----
// Sequential signed-by-unsigned multiplier, one 4-bit digit per cycle.
module fpgu_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [fpgu_pkg::XW-1:0]   x,
  input  logic        [fpgu_pkg::YW-1:0]   y,
  output logic                             busy,
  output logic                             done,
  output logic signed [fpgu_pkg::PW-1:0]   prod
);

  logic signed [fpgu_pkg::PW-1:0]   xs;
  logic        [fpgu_pkg::YW-1:0]   ys;
  logic        [fpgu_pkg::STEPW-1:0] cnt;
  logic signed [fpgu_pkg::DIGW:0]   dig;
  logic signed [fpgu_pkg::PW-1:0]   partial;

  assign dig     = $signed({1'b0, ys[fpgu_pkg::DIGW-1:0]});
  assign partial = fpgu_pkg::PW'(xs * dig);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == fpgu_pkg::STEPW'(fpgu_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= fpgu_pkg::PW'(x);
      ys   <= y;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + partial;
      xs   <= xs <<< fpgu_pkg::DIGW;
      ys   <= ys >> fpgu_pkg::DIGW;
    end
  end

endmodule

// ----- rtl/fpgu_dp.sv -----
// Datapath: count state, payoff and fitness products, compares and result register.
`include "assert_macros.svh"

module fpgu_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  fpgu_pkg::cfg_t                cfg,
  input  logic                          init_load,
  input  logic [fpgu_pkg::CW-1:0]       init_value,
  input  logic [fpgu_pkg::RW-1:0]       rand_first,
  input  logic [fpgu_pkg::RW-1:0]       rand_second,
  input  logic [fpgu_pkg::RW-1:0]       rand_third,
  input  fpgu_pkg::ctrl_cmd_t           cmd,
  output fpgu_pkg::dp_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpgu_pkg::CW-1:0]       count_a,
  output fpgu_pkg::change_t             change
);

  logic [fpgu_pkg::CW-1:0] a_count;
  logic [fpgu_pkg::RW-1:0] r1, r2, r3;
  logic [fpgu_pkg::CW-1:0] n, i, ni;
  logic [fpgu_pkg::DW-1:0] d;
  logic [fpgu_pkg::WW-1:0] w;
  logic first_u, second_a, second_b;

  logic signed [fpgu_pkg::PAYW-1:0] bn, cd, scale;
  logic signed [fpgu_pkg::WPW-1:0]  wpa, wpb;
  logic signed [fpgu_pkg::XW-1:0]   fa, fb;
  logic signed [fpgu_pkg::PW-1:0]   lft, rgt;

  // setup values
  logic [fpgu_pkg::CW-1:0] n_cl, i_cl;
  logic [fpgu_pkg::WW-1:0] w_cl;

  // pick compares
  logic [fpgu_pkg::PKW-1:0] rn1, rn2, i_sh;

  // operand selection
  logic signed [fpgu_pkg::PARW:0]   e;
  logic [fpgu_pkg::WW-1:0]          ae;
  logic signed [fpgu_pkg::PAYW-1:0] pa, pb, gap, diff, g;
  logic signed [fpgu_pkg::XW-1:0]   mx;
  logic [fpgu_pkg::YW-1:0]          my;

  logic                           mul_busy, mul_done;
  logic signed [fpgu_pkg::PW-1:0] mul_prod;

  // decision
  logic              less, first;
  fpgu_pkg::change_t chg_raw, chg;
  logic [fpgu_pkg::CW-1:0] count_new;

  always_comb begin
    if (cfg.population_size < fpgu_pkg::CW'(2))
      n_cl = fpgu_pkg::CW'(2);
    else if (cfg.population_size > fpgu_pkg::CW'(fpgu_pkg::MAX_POPULATION))
      n_cl = fpgu_pkg::CW'(fpgu_pkg::MAX_POPULATION);
    else
      n_cl = cfg.population_size;
    i_cl = (a_count > n_cl) ? n_cl : a_count;
    w_cl = (cfg.selection_strength > fpgu_pkg::WW'(fpgu_pkg::ONE_Q16)) ?
           fpgu_pkg::WW'(fpgu_pkg::ONE_Q16) : cfg.selection_strength;
  end

  assign rn1  = fpgu_pkg::PKW'(r1) * fpgu_pkg::PKW'(n);
  assign rn2  = fpgu_pkg::PKW'(r2) * fpgu_pkg::PKW'(n);
  assign i_sh = fpgu_pkg::PKW'(i) << fpgu_pkg::RW;

  // b+c, |b+c| and the payoff gap (pi_other - pi_self) sign-adjusted by b+c
  assign e    = (fpgu_pkg::PARW+1)'(cfg.benefit) + (fpgu_pkg::PARW+1)'(cfg.cost_term);
  assign ae   = e[fpgu_pkg::PARW] ? fpgu_pkg::WW'(-e) : fpgu_pkg::WW'(e);
  assign pa   = cd + bn;
  assign pb   = bn - fpgu_pkg::PAYW'(cfg.benefit);
  assign gap  = cd + fpgu_pkg::PAYW'(cfg.benefit);   // pi_a - pi_b, times N-1
  assign diff = first_u ? -gap : gap;
  assign g    = e[fpgu_pkg::PARW] ? -diff : diff;

  always_comb begin
    mx = '0;
    my = '0;
    unique case (cmd.op)
      fpgu_pkg::OP_BN: begin
        mx = fpgu_pkg::XW'(cfg.benefit);
        my = fpgu_pkg::YW'(ni);
      end
      fpgu_pkg::OP_CD: begin
        mx = fpgu_pkg::XW'(cfg.cost_term);
        my = fpgu_pkg::YW'(d);
      end
      fpgu_pkg::OP_WD: begin
        mx = fpgu_pkg::XW'(fpgu_pkg::WW'(fpgu_pkg::ONE_Q16) - w);
        my = fpgu_pkg::YW'(d);
      end
      fpgu_pkg::OP_WPA: begin
        mx = fpgu_pkg::XW'(pa);
        my = fpgu_pkg::YW'(w);
      end
      fpgu_pkg::OP_WPB: begin
        mx = fpgu_pkg::XW'(pb);
        my = fpgu_pkg::YW'(w);
      end
      fpgu_pkg::OP_FA: begin
        mx = (fpgu_pkg::XW'(scale) <<< 8) + fpgu_pkg::XW'(wpa);
        my = fpgu_pkg::YW'(i);
      end
      fpgu_pkg::OP_FB: begin
        mx = (fpgu_pkg::XW'(scale) <<< 8) + fpgu_pkg::XW'(wpb);
        my = fpgu_pkg::YW'(ni);
      end
      fpgu_pkg::OP_LFT: begin
        mx = fb;
        my = fpgu_pkg::YW'(r1);
      end
      fpgu_pkg::OP_RGT: begin
        mx = fa;
        my = fpgu_pkg::WW'(fpgu_pkg::ONE_Q16) - fpgu_pkg::WW'(r1);
      end
      fpgu_pkg::OP_QE: begin
        mx = fpgu_pkg::XW'(ae);
        my = fpgu_pkg::YW'(d);
      end
      fpgu_pkg::OP_LHS: begin
        mx = fpgu_pkg::XW'(scale);
        my = fpgu_pkg::YW'(r3);
      end
      fpgu_pkg::OP_WG: begin
        mx = fpgu_pkg::XW'(g);
        my = fpgu_pkg::YW'(w);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  fpgu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Moran: first pick is A when FB*r1 < FA*(1-r1).
  // Local: imitation when 2*r3*q < 65536*q + w*g, same register pair.
  assign less  = lft < rgt;
  assign first = (cfg.update_rule == fpgu_pkg::RULE_MORAN) ? less : first_u;

  always_comb begin
    chg_raw = fpgu_pkg::CHG_NONE;
    if (cfg.update_rule == fpgu_pkg::RULE_MORAN) begin
      if (first && second_b)       chg_raw = fpgu_pkg::CHG_INC;
      else if (!first && second_a) chg_raw = fpgu_pkg::CHG_DEC;
    end else begin
      if (first && second_b && less)       chg_raw = fpgu_pkg::CHG_DEC;
      else if (!first && second_a && less) chg_raw = fpgu_pkg::CHG_INC;
    end
    chg       = fpgu_pkg::CHG_NONE;
    count_new = i;
    if (chg_raw == fpgu_pkg::CHG_INC && i < n) begin
      chg       = fpgu_pkg::CHG_INC;
      count_new = i + 1'b1;
    end else if (chg_raw == fpgu_pkg::CHG_DEC && i != '0) begin
      chg       = fpgu_pkg::CHG_DEC;
      count_new = i - 1'b1;
    end
  end

  assign status.mul_busy = mul_busy;
  assign status.mul_done = mul_done;
  assign status.rule     = cfg.update_rule;
  assign status.out_free = !out_valid || out_ready;

  // control state: count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_count   <= fpgu_pkg::RST_INITIAL_COUNT;
      out_valid <= 1'b0;
    end else begin
      if (init_load)
        a_count <= init_value;
      else if (cmd.out_load)
        a_count <= count_new;
      if (cmd.out_load)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r1 <= rand_first;
      r2 <= rand_second;
      r3 <= rand_third;
    end
    if (cmd.setup) begin
      n  <= n_cl;
      i  <= i_cl;
      ni <= n_cl - i_cl;
      d  <= fpgu_pkg::DW'(n_cl - 1'b1);
      w  <= w_cl;
    end
    if (cmd.pick) begin
      first_u  <= rn1 < i_sh;
      second_a <= rn2 < i_sh;
      second_b <= rn2 > i_sh;
    end
    if (mul_done) begin
      unique case (cmd.op)
        fpgu_pkg::OP_BN:  bn    <= mul_prod[fpgu_pkg::PAYW-1:0];
        fpgu_pkg::OP_CD:  cd    <= mul_prod[fpgu_pkg::PAYW-1:0];
        fpgu_pkg::OP_WD:  scale <= mul_prod[fpgu_pkg::PAYW-1:0];
        fpgu_pkg::OP_WPA: wpa   <= mul_prod[fpgu_pkg::WPW-1:0];
        fpgu_pkg::OP_WPB: wpb   <= mul_prod[fpgu_pkg::WPW-1:0];
        fpgu_pkg::OP_FA:  fa    <= mul_prod[fpgu_pkg::XW-1:0];
        fpgu_pkg::OP_FB:  fb    <= mul_prod[fpgu_pkg::XW-1:0];
        fpgu_pkg::OP_LFT: lft   <= mul_prod;
        fpgu_pkg::OP_RGT: rgt   <= mul_prod;
        fpgu_pkg::OP_QE:  scale <= mul_prod[fpgu_pkg::PAYW-1:0];
        fpgu_pkg::OP_LHS: lft   <= mul_prod <<< 1;
        fpgu_pkg::OP_WG:  rgt   <= mul_prod + (fpgu_pkg::PW'(scale) <<< fpgu_pkg::RW);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      count_a <= count_new;
      change  <= chg;
    end
  end

  `ASSERT_IMPLIES(a_inc_room, clk, rst, cmd.out_load && chg == fpgu_pkg::CHG_INC, i < n, "increment at full population")
  `ASSERT_IMPLIES(a_dec_room, clk, rst, cmd.out_load && chg == fpgu_pkg::CHG_DEC, i != '0, "decrement at zero count")

endmodule

// ----- rtl/fpgu_ctrl.sv -----
// Controller: sequences setup, the product steps and the result write.
`include "assert_macros.svh"

module fpgu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output fpgu_pkg::ctrl_cmd_t   cmd,
  input  fpgu_pkg::dp_status_t  status
);

  fpgu_pkg::state_t state, state_next;
  fpgu_pkg::op_t    op, op_next;

  function automatic fpgu_pkg::op_t follow(input fpgu_pkg::op_t cur);
    fpgu_pkg::op_t nx;
    unique case (cur)
      fpgu_pkg::OP_BN:  nx = fpgu_pkg::OP_CD;
      fpgu_pkg::OP_CD:  nx = (status.rule == fpgu_pkg::RULE_MORAN) ?
                             fpgu_pkg::OP_WD : fpgu_pkg::OP_QE;
      fpgu_pkg::OP_WD:  nx = fpgu_pkg::OP_WPA;
      fpgu_pkg::OP_WPA: nx = fpgu_pkg::OP_WPB;
      fpgu_pkg::OP_WPB: nx = fpgu_pkg::OP_FA;
      fpgu_pkg::OP_FA:  nx = fpgu_pkg::OP_FB;
      fpgu_pkg::OP_FB:  nx = fpgu_pkg::OP_LFT;
      fpgu_pkg::OP_LFT: nx = fpgu_pkg::OP_RGT;
      fpgu_pkg::OP_QE:  nx = fpgu_pkg::OP_LHS;
      fpgu_pkg::OP_LHS: nx = fpgu_pkg::OP_WG;
      default:          nx = cur;
    endcase
    return nx;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpgu_pkg::ST_IDLE;
      op    <= fpgu_pkg::OP_BN;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.setup     = 1'b0;
    cmd.pick      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.op        = op;
    cmd.out_load  = 1'b0;
    unique case (state)
      fpgu_pkg::ST_IDLE: begin
        // no requests taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = fpgu_pkg::ST_SETUP;
        end
      end
      fpgu_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = fpgu_pkg::ST_PICK;
      end
      fpgu_pkg::ST_PICK: begin
        cmd.pick   = 1'b1;
        op_next    = (status.rule == fpgu_pkg::RULE_MORAN) ?
                     fpgu_pkg::OP_BN : fpgu_pkg::OP_CD;
        state_next = fpgu_pkg::ST_MUL_START;
      end
      fpgu_pkg::ST_MUL_START: begin
        cmd.mul_start = 1'b1;
        state_next    = fpgu_pkg::ST_MUL_WAIT;
      end
      fpgu_pkg::ST_MUL_WAIT: begin
        if (status.mul_done) begin
          if (op == fpgu_pkg::OP_RGT || op == fpgu_pkg::OP_WG) begin
            state_next = fpgu_pkg::ST_DECIDE;
          end else begin
            op_next    = follow(op);
            state_next = fpgu_pkg::ST_MUL_START;
          end
        end
      end
      fpgu_pkg::ST_DECIDE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fpgu_pkg::ST_IDLE;
        end
      end
      default: state_next = fpgu_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_load_free, clk, rst, cmd.out_load, status.out_free, "result written over a waiting one")
  `ASSERT_IMPLIES(a_mul_idle, clk, rst, cmd.mul_start, !status.mul_busy, "multiplier restarted while busy")
  `ASSERT_NEXT(a_mul_runs, clk, rst, cmd.mul_start, status.mul_busy, "multiplier did not start")

endmodule

// ----- rtl/finite_population_game_update_unit.sv -----
// Top level: config registers, controller and datapath of the game update unit.
//
// Keeps the number of strategy-A individuals in a population of N and runs one
// stochastic update (Moran or local pairwise imitation) per input request.
// Input channel s_*: one request carries three Q0.16 random fractions.
// Output channel m_*: one result per request, the new count and the change code.
// Config channel cfg_*: index plus data, ready whenever out of reset; write only while idle.
// Writing initial_count also reloads the count at once.
// Products: all products run on one shared multiplier that takes one
// 4-bit digit of its multiplier per cycle; each product step starts it and waits for done.
// Moran mode uses 9 product steps, local mode uses 4.
// One request is worked on at a time; the next one is taken while the previous
// result still waits in the output register.
// Reset: config registers take their reset values, the count is 50, channels idle.
// A stalled receiver holds the result; a finished update then waits for the slot
// and new requests are held off until it is written.
module finite_population_game_update_unit (
  input  logic                        clk,
  input  logic                        rst,
  // input requests
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,    // rand_first, rand_second, rand_third
  // results
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,    // count_a[12:0], change[14:13], zero pad
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fpgu_pkg::CIW-1:0]    cfg_index,
  input  logic [fpgu_pkg::CDW-1:0]    cfg_data
);

  fpgu_pkg::cfg_t        cfg;
  fpgu_pkg::ctrl_cmd_t   cmd;
  fpgu_pkg::dp_status_t  status;
  logic                  cfg_we, init_load;
  logic [fpgu_pkg::CW-1:0] count_a;
  fpgu_pkg::change_t     change;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign init_load = cfg_we && (cfg_index == fpgu_pkg::CFG_INITIAL_COUNT);

  // Config register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.population_size    <= fpgu_pkg::RST_POPULATION_SIZE;
      cfg.selection_strength <= fpgu_pkg::RST_SELECTION_STRENGTH;
      cfg.benefit            <= fpgu_pkg::RST_BENEFIT;
      cfg.cost_term          <= fpgu_pkg::RST_COST_TERM;
      cfg.update_rule        <= fpgu_pkg::RST_UPDATE_RULE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpgu_pkg::CFG_POPULATION_SIZE:    cfg.population_size    <= cfg_data[fpgu_pkg::CW-1:0];
        fpgu_pkg::CFG_SELECTION_STRENGTH: cfg.selection_strength <= cfg_data[fpgu_pkg::WW-1:0];
        fpgu_pkg::CFG_BENEFIT:            cfg.benefit            <= cfg_data[fpgu_pkg::PARW-1:0];
        fpgu_pkg::CFG_COST_TERM:          cfg.cost_term          <= cfg_data[fpgu_pkg::PARW-1:0];
        fpgu_pkg::CFG_UPDATE_RULE:        cfg.update_rule        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fpgu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  fpgu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .init_load   (init_load),
    .init_value  (cfg_data[fpgu_pkg::CW-1:0]),
    .rand_first  (s_tdata[15:0]),
    .rand_second (s_tdata[31:16]),
    .rand_third  (s_tdata[47:32]),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .count_a     (count_a),
    .change      (change)
  );

  assign m_tdata = {1'b0, change, count_a};

endmodule
